// ===== design/mpdu_pkg.sv =====
`timescale 1ns / 1ps

package mpdu_pkg;

   localparam int CH_W       = 6;
   localparam int BYTE_W     = 8;
   localparam int POS_W      = 11;
   localparam int LEN_W      = 10;
   localparam int FC_W       = 24;
   localparam int HP_W       = 11;
   localparam int SC_W       = 8;
   localparam int VER_W      = 2;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;

   localparam int DEF_DATA_FIELD_BYTES = 882;
   localparam int DEF_CHANNEL_COUNT    = 64;

   localparam int MID_DEPTH = 4;
   localparam int RSP_DEPTH = 4;

   localparam logic [HP_W-1:0] NO_HEADER = 11'h7FF;

   localparam logic [SC_W-1:0]  SC_RESET  = 8'd69;
   localparam logic [VER_W-1:0] VER_RESET = 2'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_SPACECRAFT_ID = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_VERSION = 8'd1;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_CLOSE = 1'b1;

   typedef struct packed {
      logic [CH_W-1:0]   ch;
      logic [BYTE_W-1:0] data;
      logic              pkt_start;
      logic              pkt_end;
      logic              flush;
   } item_type;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic [HP_W-1:0]  fpo;
      logic [FC_W-1:0]  fc;
   } state_type;

   localparam state_type STATE_RESET = '{pos: '0, fpo: NO_HEADER, fc: '0};

   typedef struct packed {
      logic              kind;
      logic [CH_W-1:0]   ch;
      logic [LEN_W-1:0]  len;
      logic [BYTE_W-1:0] data;
      logic [FC_W-1:0]   fc;
      logic [HP_W-1:0]   hp;
      logic              last;
   } rsp_type;

endpackage

// ===== design/mpdu_fifo.sv =====
`timescale 1ns / 1ps

module mpdu_fifo #(
   parameter int W     = 8,
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] din,
   input  logic         pop,
   output logic [W-1:0] dout,
   output logic         empty,
   output logic         full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [W-1:0]     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ===== design/mpdu_front.sv =====
`timescale 1ns / 1ps

module mpdu_front #(
   parameter int CHANNEL_COUNT = mpdu_pkg::DEF_CHANNEL_COUNT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  logic [mpdu_pkg::CH_W-1:0]     req_channel,
   input  logic [mpdu_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                          req_packet_start,
   input  logic                          req_packet_end,
   input  logic                          req_flush,
   output logic                          req_full,
   input  logic                          item_pop,
   output mpdu_pkg::item_type            item_head,
   output logic                          item_empty
);

   mpdu_pkg::item_type item_in;
   logic               in_range;
   logic [$bits(mpdu_pkg::item_type)-1:0] head_bits;

   // Bytes on channels beyond the configured count are taken and discarded.
   assign in_range = {1'b0, req_channel} < (mpdu_pkg::CH_W + 1)'(CHANNEL_COUNT);

   always_comb begin
      item_in.ch        = req_channel;
      item_in.data      = req_data_byte;
      item_in.pkt_start = req_packet_start;
      item_in.pkt_end   = req_packet_end;
      item_in.flush     = req_flush;
   end

   mpdu_fifo #(
      .W     ($bits(mpdu_pkg::item_type)),
      .DEPTH (mpdu_pkg::MID_DEPTH)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (req_push && in_range),
      .din   (item_in),
      .pop   (item_pop),
      .dout  (head_bits),
      .empty (item_empty),
      .full  (req_full)
   );

   assign item_head = mpdu_pkg::item_type'(head_bits);

endmodule

// ===== design/mpdu_back.sv =====
`timescale 1ns / 1ps

module mpdu_back #(
   parameter int DATA_FIELD_BYTES = mpdu_pkg::DEF_DATA_FIELD_BYTES,
   parameter int CHANNEL_COUNT    = mpdu_pkg::DEF_CHANNEL_COUNT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_empty,
   input  mpdu_pkg::item_type item_head,
   output logic               item_pop,
   input  logic               rsp_full,
   output logic               rsp_push,
   output mpdu_pkg::rsp_type  rsp_out
);

   localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

   localparam logic PH_WRITE = 1'b0;
   localparam logic PH_CLOSE = 1'b1;

   mpdu_pkg::state_type state_mem [CHANNEL_COUNT];
   logic [CHANNEL_COUNT-1:0] vld_ff, vld_in;

   mpdu_pkg::item_type  s2_item_ff;
   logic                s2_vld_ff, s2_vld_in;
   logic                phase_ff, phase_in;
   mpdu_pkg::state_type rd_ff;
   logic                rd_vld_ff;
   logic                byp_vld_ff, byp_vld_in;
   logic [IDX_W-1:0]    byp_idx_ff;
   mpdu_pkg::state_type byp_st_ff;

   logic [IDX_W-1:0]      head_idx;
   logic [IDX_W-1:0]      s2_idx;
   mpdu_pkg::state_type   cur;
   mpdu_pkg::state_type   upd;
   logic [mpdu_pkg::HP_W-1:0]  fpo_new;
   logic [mpdu_pkg::POS_W:0]   pos_next;
   logic                  close;
   logic                  retire;
   logic                  load;

   assign head_idx = item_head.ch[IDX_W-1:0];
   assign s2_idx   = s2_item_ff.ch[IDX_W-1:0];

   // The bypass register always holds the most recent state write, so a hit on it
   // is newer than anything the memory read could have returned.
   always_comb begin
      if (byp_vld_ff && (byp_idx_ff == s2_idx)) begin
         cur = byp_st_ff;
      end else if (rd_vld_ff) begin
         cur = rd_ff;
      end else begin
         cur = mpdu_pkg::STATE_RESET;
      end
   end

   always_comb begin
      fpo_new  = (s2_item_ff.pkt_start && (cur.fpo == mpdu_pkg::NO_HEADER))
                 ? cur.pos : cur.fpo;
      pos_next = {1'b0, cur.pos} + 1'b1;
      close    = (pos_next >= (mpdu_pkg::POS_W + 1)'(DATA_FIELD_BYTES))
                 || (s2_item_ff.pkt_end && s2_item_ff.flush);
      if (close) begin
         upd.pos = '0;
         upd.fpo = mpdu_pkg::NO_HEADER;
         upd.fc  = cur.fc + 1'b1;
      end else begin
         upd.pos = pos_next[mpdu_pkg::POS_W-1:0];
         upd.fpo = fpo_new;
         upd.fc  = cur.fc;
      end
   end

   always_comb begin
      rsp_out = '0;
      rsp_out.ch = s2_item_ff.ch;
      unique case (phase_ff)
         PH_WRITE: begin
            rsp_out.kind = mpdu_pkg::KIND_WRITE;
            rsp_out.len  = cur.pos[mpdu_pkg::LEN_W-1:0];
            rsp_out.data = s2_item_ff.data;
            rsp_out.last = !close;
         end
         PH_CLOSE: begin
            rsp_out.kind = mpdu_pkg::KIND_CLOSE;
            rsp_out.len  = pos_next[mpdu_pkg::LEN_W-1:0];
            rsp_out.fc   = cur.fc;
            rsp_out.hp   = fpo_new;
            rsp_out.last = 1'b1;
         end
         default: begin
            rsp_out.kind = mpdu_pkg::KIND_WRITE;
         end
      endcase
   end

   // A closing byte stays here until both its write and close results are pushed.
   assign rsp_push = s2_vld_ff && !rsp_full;
   assign retire   = rsp_push && ((phase_ff == PH_CLOSE) || !close);
   assign load     = !s2_vld_ff || retire;
   assign item_pop = load && !item_empty;

   always_comb begin
      s2_vld_in  = load ? !item_empty : s2_vld_ff;
      phase_in   = phase_ff;
      vld_in     = vld_ff;
      byp_vld_in = byp_vld_ff;
      if (rsp_push) begin
         if ((phase_ff == PH_WRITE) && close) begin
            phase_in = PH_CLOSE;
         end else begin
            phase_in = PH_WRITE;
         end
      end
      if (retire) begin
         vld_in[s2_idx] = 1'b1;
         byp_vld_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff  <= 1'b0;
         phase_ff   <= PH_WRITE;
         vld_ff     <= '0;
         byp_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff  <= s2_vld_in;
         phase_ff   <= phase_in;
         vld_ff     <= vld_in;
         byp_vld_ff <= byp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s2_item_ff <= item_head;
         rd_ff      <= state_mem[head_idx];
         rd_vld_ff  <= vld_ff[head_idx];
      end
      if (retire) begin
         state_mem[s2_idx] <= upd;
         byp_idx_ff        <= s2_idx;
         byp_st_ff         <= upd;
      end
   end

endmodule

// ===== design/ccsds_mpdu_frame_packer_top.sv =====
`timescale 1ns / 1ps

// Channel   Ports                                   Moves on
// -------   -------------------------------------   ------------------------------
// request   req_push, req_full, req_* fields        req_push && !req_full
// result    rsp_empty, rsp_pop, rsp_* fields        rsp_pop && !rsp_empty
// csr       csr_valid, csr_ready, csr_index/data    csr_valid && csr_ready
//
// One request byte is taken per cycle while req_full is low; a byte that closes
// a frame holds the state sequencer until its write and close results are pushed,
// since the result queue takes one result a cycle while it is not full.
// Reset clears the per-channel valid bits at once; there is no clearing pass.
// Requests and results stall independently through the queues on either side.

module ccsds_mpdu_frame_packer_top #(
   parameter int DATA_FIELD_BYTES = mpdu_pkg::DEF_DATA_FIELD_BYTES,
   parameter int CHANNEL_COUNT    = mpdu_pkg::DEF_CHANNEL_COUNT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [mpdu_pkg::CH_W-1:0]         req_channel,
   input  logic [mpdu_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic                              req_packet_start,
   input  logic                              req_packet_end,
   input  logic                              req_flush,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic                              rsp_kind,
   output logic [mpdu_pkg::CH_W-1:0]         rsp_out_channel,
   output logic [mpdu_pkg::LEN_W-1:0]        rsp_offset,
   output logic [mpdu_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic [mpdu_pkg::FC_W-1:0]         rsp_frame_count,
   output logic [mpdu_pkg::HP_W-1:0]         rsp_header_pointer,
   output logic [mpdu_pkg::LEN_W-1:0]        rsp_used_length,
   output logic [mpdu_pkg::SC_W-1:0]         rsp_spacecraft_out,
   output logic [mpdu_pkg::VER_W-1:0]        rsp_version_out,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mpdu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mpdu_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic [mpdu_pkg::SC_W-1:0]  sc_ff, sc_in;
   logic [mpdu_pkg::VER_W-1:0] ver_ff, ver_in;

   mpdu_pkg::item_type item_head;
   logic               item_empty;
   logic               item_pop;
   logic               rsp_full;
   logic               rsp_push;
   mpdu_pkg::rsp_type  rsp_new;
   mpdu_pkg::rsp_type  rsp_head;
   logic [$bits(mpdu_pkg::rsp_type)-1:0] rsp_bits;

   assign csr_ready = 1'b1;

   always_comb begin
      sc_in  = sc_ff;
      ver_in = ver_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mpdu_pkg::CSR_SPACECRAFT_ID: sc_in  = csr_data;
            mpdu_pkg::CSR_FRAME_VERSION: ver_in = csr_data[mpdu_pkg::VER_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff  <= mpdu_pkg::SC_RESET;
         ver_ff <= mpdu_pkg::VER_RESET;
      end else begin
         sc_ff  <= sc_in;
         ver_ff <= ver_in;
      end
   end

   mpdu_front #(
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_channel      (req_channel),
      .req_data_byte    (req_data_byte),
      .req_packet_start (req_packet_start),
      .req_packet_end   (req_packet_end),
      .req_flush        (req_flush),
      .req_full         (req_full),
      .item_pop         (item_pop),
      .item_head        (item_head),
      .item_empty       (item_empty)
   );

   mpdu_back #(
      .DATA_FIELD_BYTES (DATA_FIELD_BYTES),
      .CHANNEL_COUNT    (CHANNEL_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_empty (item_empty),
      .item_head  (item_head),
      .item_pop   (item_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_out    (rsp_new)
   );

   mpdu_fifo #(
      .W     ($bits(mpdu_pkg::rsp_type)),
      .DEPTH (mpdu_pkg::RSP_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (rsp_new),
      .pop   (rsp_pop),
      .dout  (rsp_bits),
      .empty (rsp_empty),
      .full  (rsp_full)
   );

   assign rsp_head = mpdu_pkg::rsp_type'(rsp_bits);

   // User changes header registers only while idle (not enforced); added at output.
   always_comb begin
      rsp_kind           = rsp_head.kind;
      rsp_out_channel    = rsp_head.ch;
      rsp_out_byte       = rsp_head.data;
      rsp_frame_count    = rsp_head.fc;
      rsp_header_pointer = rsp_head.hp;
      rsp_last           = rsp_head.last;
      if (rsp_head.kind == mpdu_pkg::KIND_CLOSE) begin
         rsp_offset         = '0;
         rsp_used_length    = rsp_head.len;
         rsp_spacecraft_out = sc_ff;
         rsp_version_out    = ver_ff;
      end else begin
         rsp_offset         = rsp_head.len;
         rsp_used_length    = '0;
         rsp_spacecraft_out = '0;
         rsp_version_out    = '0;
      end
   end

   a_reset_clears_queues: assert property (@(posedge clock)
      reset |=> (!req_full && rsp_empty))
      else $error("queues not empty after reset");

   a_close_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_kind == mpdu_pkg::KIND_CLOSE)) |-> rsp_last)
      else $error("close result without last mark");

   a_close_follows_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && (rsp_kind == mpdu_pkg::KIND_WRITE) && !rsp_last)
      |=> (rsp_empty || ((rsp_kind == mpdu_pkg::KIND_CLOSE)
                         && (rsp_out_channel == $past(rsp_out_channel)))))
      else $error("write result not followed by its close result");

endmodule
